// File: rtl/erpt_pkg.sv
// ============================================================================
// erpt_pkg
// Shared types, constants and tables of the Euler-angle rigid point transform.
// ============================================================================
package erpt_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int ANGLE_WIDTH = 17;
   localparam int TRIG_WIDTH = 32;
   localparam int TRIG_FRAC = 30;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_WIDTH = 4;
   localparam int ZW = 25;
   localparam int CW = 34;
   localparam int NUM_ANGLES = 3;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic signed [ANGLE_WIDTH:0] HALF_TURN = 18'sd46080;
   localparam logic signed [ANGLE_WIDTH:0] QUARTER_TURN = 18'sd23040;
   localparam logic signed [ANGLE_WIDTH:0] FULL_TURN = 18'sd92160;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_YAW = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PITCH = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROLL = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_Z = 3'd5;

   // Slots of the angle and trig arrays.
   localparam logic [1:0] ANG_YAW = 2'd0;
   localparam logic [1:0] ANG_PITCH = 2'd1;
   localparam logic [1:0] ANG_ROLL = 2'd2;

   typedef struct packed {
      logic [NUM_ANGLES-1:0][TRIG_WIDTH-1:0] sin_val;
      logic [NUM_ANGLES-1:0][TRIG_WIDTH-1:0] cos_val;
      logic                                  busy;
   } trig_type;

   // Arctangent of 2^-i in units of 2^-16 degree.
   function automatic logic signed [ZW-1:0] atan_val(input logic [STEP_WIDTH-1:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         4'd0: r = 25'sd2949120;
         4'd1: r = 25'sd1740967;
         4'd2: r = 25'sd919879;
         4'd3: r = 25'sd466945;
         4'd4: r = 25'sd234379;
         4'd5: r = 25'sd117304;
         4'd6: r = 25'sd58666;
         4'd7: r = 25'sd29335;
         4'd8: r = 25'sd14668;
         4'd9: r = 25'sd7334;
         4'd10: r = 25'sd3667;
         4'd11: r = 25'sd1833;
         4'd12: r = 25'sd917;
         4'd13: r = 25'sd458;
         4'd14: r = 25'sd229;
         4'd15: r = 25'sd115;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/erpt_cordic.sv
// ============================================================================
// erpt_cordic
// Sequential CORDIC that turns the three angle registers into sine and cosine.
// ============================================================================
module erpt_cordic
   import erpt_pkg::*;
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   angle_wr,
   input  logic [NUM_ANGLES-1:0][ANGLE_WIDTH-1:0] angles,
   output trig_type                               trig
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  pend_ff, pend_in;
   logic [1:0]            sel_ff, sel_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic signed [CW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic                  neg_ff, neg_in;
   logic [NUM_ANGLES-1:0][TRIG_WIDTH-1:0] sin_ff, cos_ff;

   logic signed [ANGLE_WIDTH:0] a_full, a_half, a_red;
   logic                        a_neg;
   logic signed [CW-1:0]        xs, ys, x_nx, y_nx, cos_nx, sin_nx;
   logic                        last_step;

   // Fold the angle into [-90, 90] degrees; beyond that both results flip sign.
   always_comb begin
      a_full = {angles[sel_ff][ANGLE_WIDTH-1], angles[sel_ff]};
      if (a_full > HALF_TURN) begin
         a_half = a_full - FULL_TURN;
      end else if (a_full < -HALF_TURN) begin
         a_half = a_full + FULL_TURN;
      end else begin
         a_half = a_full;
      end
      a_neg = 1'b1;
      if (a_half > QUARTER_TURN) begin
         a_red = a_half - HALF_TURN;
      end else if (a_half < -QUARTER_TURN) begin
         a_red = a_half + HALF_TURN;
      end else begin
         a_red = a_half;
         a_neg = 1'b0;
      end
   end

   always_comb begin
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      if (!z_ff[ZW-1]) begin
         x_nx = x_ff - ys;
         y_nx = y_ff + xs;
      end else begin
         x_nx = x_ff + ys;
         y_nx = y_ff - xs;
      end
      cos_nx = neg_ff ? -x_nx : x_nx;
      sin_nx = neg_ff ? -y_nx : y_nx;
      last_step = (step_ff == STEP_WIDTH'(CORDIC_STEPS - 1));
   end

   always_comb begin
      state_in = state_ff;
      pend_in = pend_ff | angle_wr;
      sel_in = sel_ff;
      step_in = step_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      neg_in = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pend_ff) begin
               state_in = ST_LOAD;
               pend_in = angle_wr;
               sel_in = ANG_YAW;
            end
         end
         ST_LOAD: begin
            x_in = CORDIC_GAIN;
            y_in = '0;
            // The folded angle fits in 17 bits, so its top sign bit can go.
            z_in = {a_red[ZW-9:0], 8'd0};
            neg_in = a_neg;
            step_in = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            x_in = x_nx;
            y_in = y_nx;
            z_in = z_ff[ZW-1] ? z_ff + atan_val(step_ff) : z_ff - atan_val(step_ff);
            step_in = step_ff + 1'b1;
            if (last_step) begin
               if (sel_ff == ANG_ROLL) begin
                  state_in = ST_IDLE;
               end else begin
                  sel_in = sel_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
      end
      sel_ff <= sel_in;
      step_ff <= step_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      neg_ff <= neg_in;
      if (state_ff == ST_RUN && last_step) begin
         cos_ff[sel_ff] <= cos_nx[TRIG_WIDTH-1:0];
         sin_ff[sel_ff] <= sin_nx[TRIG_WIDTH-1:0];
      end
   end

   assign trig.sin_val = sin_ff;
   assign trig.cos_val = cos_ff;
   assign trig.busy = pend_ff || (state_ff != ST_IDLE);

endmodule

// File: rtl/erpt_rot.sv
// ============================================================================
// erpt_rot
// Two-stage pipelined plane rotation: a' = a*c - b*s, b' = a*s + b*c.
// ============================================================================
module erpt_rot
   import erpt_pkg::*;
#(
   parameter int IW = COORD_WIDTH_DEFAULT
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [IW-1:0]         in_a,
   input  logic signed [IW-1:0]         in_b,
   input  logic signed [IW-1:0]         in_c,
   input  logic signed [TRIG_WIDTH-1:0] sin_val,
   input  logic signed [TRIG_WIDTH-1:0] cos_val,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [IW:0]           out_a,
   output logic signed [IW:0]           out_b,
   output logic signed [IW:0]           out_c
);

   localparam int PW = IW + TRIG_WIDTH;
   localparam int RW = PW + 1 - TRIG_FRAC;
   localparam int OW = IW + 1;

   logic                 v1_ff, v2_ff, s1_load, s2_load;
   logic signed [PW-1:0] pac_ff, pbs_ff, pas_ff, pbc_ff;
   logic signed [IW-1:0] c1_ff;
   logic signed [OW-1:0] a2_ff, a2_in, b2_ff, b2_in;
   logic signed [OW-1:0] c2_ff;
   logic signed [RW-1:0] rac, rbs, ras, rbc, sum_a, sum_b;

   // Rounds a Q.30 product to the nearest integer, ties away from zero.
   function automatic logic signed [RW-1:0] round_q30(input logic signed [PW-1:0] p);
      logic signed [PW:0] e, m;
      e = {p[PW-1], p};
      m = p[PW-1] ? -e : e;
      m = (m + ((PW + 1)'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      return p[PW-1] ? -m[RW-1:0] : m[RW-1:0];
   endfunction

   assign s2_load = !v2_ff || out_ready;
   assign s1_load = !v1_ff || s2_load;
   assign in_ready = s1_load;

   always_comb begin
      rac = round_q30(pac_ff);
      rbs = round_q30(pbs_ff);
      ras = round_q30(pas_ff);
      rbc = round_q30(pbc_ff);
      sum_a = rac - rbs;
      sum_b = ras + rbc;
      a2_in = sum_a[OW-1:0];
      b2_in = sum_b[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            v1_ff <= in_valid;
         end
         if (s2_load) begin
            v2_ff <= v1_ff;
         end
      end
      if (s1_load) begin
         pac_ff <= PW'(in_a * cos_val);
         pbs_ff <= PW'(in_b * sin_val);
         pas_ff <= PW'(in_a * sin_val);
         pbc_ff <= PW'(in_b * cos_val);
         c1_ff <= in_c;
      end
      if (s2_load) begin
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         c2_ff <= {c1_ff[IW-1], c1_ff};
      end
   end

   assign out_valid = v2_ff;
   assign out_a = a2_ff;
   assign out_b = b2_ff;
   assign out_c = c2_ff;

endmodule

// File: rtl/euler_rigid_point_transform.sv
// ============================================================================
// euler_rigid_point_transform
// Rotates a Q16.16 point about X (pitch), Y (yaw), Z (roll), then translates.
// ============================================================================
// Usage: points enter on the req_ channel (req_in_x/y/z) and leave on the
// rsp_ channel (rsp_out_x/y/z), one result per point, in order. Angles and
// the translation are written on the csr_ channel, which is always ready.
// On its way to the output a point passes seven register stages: two per
// rotation (products, then rounding and sum) and one for translation and
// saturation. One point can be accepted every cycle while the receiver
// keeps up and the CORDIC is not busy. When the receiver stalls, the
// pipeline fills its empty stages and then drops req_ready; nothing is lost.
// Sine and cosine come from a shared sequential CORDIC: after reset and
// after every angle write req_ready stays low while it leaves its idle
// state and runs one load plus 16 steps for each of the three angles.
// Reset clears the configuration to zero and empties the pipeline.
// ============================================================================
module euler_rigid_point_transform
   import erpt_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [COORD_WIDTH-1:0]   req_in_x,
   input  logic signed [COORD_WIDTH-1:0]   req_in_y,
   input  logic signed [COORD_WIDTH-1:0]   req_in_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [COORD_WIDTH-1:0]   rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]   rsp_out_z,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] csr_wdata
);

   localparam int W = COORD_WIDTH;
   localparam int FW = W + 3;
   localparam int SW = W + 4;
   localparam logic signed [SW-1:0] SAT_HI = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   logic [NUM_ANGLES-1:0][ANGLE_WIDTH-1:0] angle_ff;
   logic signed [W-1:0] shx_ff, shy_ff, shz_ff;
   logic                csr_xfer, angle_wr;
   trig_type            trig;

   logic               p_in_valid, p_in_ready, p_valid, y_ready;
   logic signed [W:0]  p_a, p_b, p_c;
   logic               y_valid, r_ready;
   logic signed [W+1:0] y_a, y_b, y_c;
   logic               r_valid, o_load;
   logic signed [FW-1:0] r_a, r_b, r_c;
   logic signed [SW-1:0] sum_x, sum_y, sum_z;
   logic               o_valid_ff;
   logic signed [W-1:0] ox_ff, oy_ff, oz_ff;

   function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[W-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign csr_xfer = csr_valid && csr_ready;
   assign angle_wr = csr_xfer &&
      (csr_index == CSR_YAW || csr_index == CSR_PITCH || csr_index == CSR_ROLL);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         shx_ff <= '0;
         shy_ff <= '0;
         shz_ff <= '0;
      end else if (csr_xfer) begin
         case (csr_index)
            CSR_YAW:     angle_ff[ANG_YAW] <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_PITCH:   angle_ff[ANG_PITCH] <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_ROLL:    angle_ff[ANG_ROLL] <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_SHIFT_X: shx_ff <= csr_wdata[W-1:0];
            CSR_SHIFT_Y: shy_ff <= csr_wdata[W-1:0];
            CSR_SHIFT_Z: shz_ff <= csr_wdata[W-1:0];
            default: ;
         endcase
      end
   end

   erpt_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .angle_wr (angle_wr),
      .angles   (angle_ff),
      .trig     (trig)
   );

   assign p_in_valid = req_valid && !trig.busy;
   assign req_ready = p_in_ready && !trig.busy;

   // Pitch about X rotates (y, z); x rides along.
   erpt_rot #(.IW(W)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_in_valid),
      .in_ready  (p_in_ready),
      .in_a      (req_in_y),
      .in_b      (req_in_z),
      .in_c      (req_in_x),
      .sin_val   (trig.sin_val[ANG_PITCH]),
      .cos_val   (trig.cos_val[ANG_PITCH]),
      .out_valid (p_valid),
      .out_ready (y_ready),
      .out_a     (p_a),
      .out_b     (p_b),
      .out_c     (p_c)
   );

   // Yaw about Y rotates (z, x); y rides along.
   erpt_rot #(.IW(W + 1)) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (y_ready),
      .in_a      (p_b),
      .in_b      (p_c),
      .in_c      (p_a),
      .sin_val   (trig.sin_val[ANG_YAW]),
      .cos_val   (trig.cos_val[ANG_YAW]),
      .out_valid (y_valid),
      .out_ready (r_ready),
      .out_a     (y_a),
      .out_b     (y_b),
      .out_c     (y_c)
   );

   // Roll about Z rotates (x, y); z rides along.
   erpt_rot #(.IW(W + 2)) u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (y_valid),
      .in_ready  (r_ready),
      .in_a      (y_b),
      .in_b      (y_c),
      .in_c      (y_a),
      .sin_val   (trig.sin_val[ANG_ROLL]),
      .cos_val   (trig.cos_val[ANG_ROLL]),
      .out_valid (r_valid),
      .out_ready (o_load),
      .out_a     (r_a),
      .out_b     (r_b),
      .out_c     (r_c)
   );

   assign o_load = !o_valid_ff || rsp_ready;

   always_comb begin
      sum_x = {r_a[FW-1], r_a} + SW'(shx_ff);
      sum_y = {r_b[FW-1], r_b} + SW'(shy_ff);
      sum_z = {r_c[FW-1], r_c} + SW'(shz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_load) begin
         o_valid_ff <= r_valid;
      end
      if (o_load) begin
         ox_ff <= sat(sum_x);
         oy_ff <= sat(sum_y);
         oz_ff <= sat(sum_z);
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_out_x = ox_ff;
   assign rsp_out_y = oy_ff;
   assign rsp_out_z = oz_ff;

endmodule

// File: rtl/erpt_checker.sv
// ============================================================================
// erpt_checker
// Port-level checks of the rigid point transform, bound to the top level.
// ============================================================================
module erpt_checker
   import erpt_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [COORD_WIDTH-1:0] rsp_out_x,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input logic [CSR_INDEX_WIDTH-1:0] csr_index
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("result dropped or changed while stalled");

   // Trig values are rebuilt after reset, so no point is taken right away.
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input accepted before trig values were ready");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // An angle write must block input until the new trig values exist.
   a_angle_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready &&
      (csr_index == CSR_YAW || csr_index == CSR_PITCH || csr_index == CSR_ROLL)
      |=> !req_ready)
      else $error("input accepted while trig values were stale");

endmodule

bind euler_rigid_point_transform erpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_erpt_checker (.*);
